// ===== sv/rrpq_pkg.sv =====
// Shared constants, codes and control types for the route request packet queue.
// No dependencies.
package rrpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int AGE_W       = 17;
    localparam int OCC_W       = 5;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ENQ    = 3'd1;
    localparam logic [2:0] OP_DEQ    = 3'd2;
    localparam logic [2:0] OP_DROP   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;
    localparam logic [2:0] OP_SIZE   = 3'd5;
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    localparam logic [1:0] K_EXP  = 2'd0;
    localparam logic [1:0] K_OLD  = 2'd1;
    localparam logic [1:0] K_DST  = 2'd2;
    localparam logic [1:0] K_DONE = 2'd3;

    localparam logic [2:0] M_PURGE = 3'd0;
    localparam logic [2:0] M_TICK  = 3'd1;
    localparam logic [2:0] M_DUP   = 3'd2;
    localparam logic [2:0] M_FIND  = 3'd3;
    localparam logic [2:0] M_DEQ   = 3'd4;
    localparam logic [2:0] M_DEST  = 3'd5;
    localparam logic [2:0] M_OLD   = 3'd6;

    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_LIFETIME   = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       walk;
        logic [2:0] mode;
        logic       append;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic hit;
        logic emit_end;
    } t_stat;

endpackage

// ===== sv/route_request_packet_queue_top.sv =====
// Top level of the route request packet queue: APB registers, sequencer and datapath.
// Depends on rrpq_pkg, rrpq_ctrl and rrpq_datapath.
//
// Usage: raise start with opcode, packet id and destination while busy is low;
// the word is taken at that edge and busy stays high until the last result.
// Results leave one word per cycle on the o_ ports, marked by o_strobe; the
// final word of an operation is the done word with o_last high. Every word of
// one operation carries the occupancy after the whole operation.
// Sequence: a purge walk (enqueue, dequeue, drop and size only), then an operation
// walk (not for size; enqueue may add an oldest-drop walk and an append step), then
// the drop words and the done word; reserved opcodes emit only the done word.
// Throughput is one operation at a time, set by the single read port the walks share.
// Registers: max_length at byte 0, lifetime_ticks at byte 4. The user must write them
// over APB only while busy is low; the block does not enforce this. Reset empties the
// queue and loads 16 and 30.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module route_request_packet_queue_top
    import rrpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_packet_id,
    input  logic [15:0] i_dest_addr,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_out_packet_id,
    output logic [15:0] o_out_dest_addr,
    output logic        o_success,
    output logic [4:0]  o_occupancy,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  r_max_length;
    logic [15:0] r_lifetime;
    t_cmd        cmd;
    t_stat       stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_LIFETIME) ? {16'd0, r_lifetime} : {27'd0, r_max_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= 5'd16;
            r_lifetime   <= 16'd30;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == CFG_LIFETIME) begin
                r_lifetime <= pwdata[15:0];
            end else begin
                r_max_length <= pwdata[4:0];
            end
        end
    end

    rrpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rrpq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_packet_id     (i_packet_id),
        .i_dest_addr     (i_dest_addr),
        .i_max_length    (r_max_length),
        .i_lifetime      (r_lifetime),
        .o_kind          (o_kind),
        .o_out_packet_id (o_out_packet_id),
        .o_out_dest_addr (o_out_dest_addr),
        .o_success       (o_success),
        .o_occupancy     (o_occupancy),
        .o_last          (o_last)
    );

    assign o_strobe = cmd.emit;

    a_no_word_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_strobe) else $error("result word while idle");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !busy) else $error("busy after last word");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_occupancy <= 5'd16) else $error("occupancy out of range");

endmodule

// ===== sv/rrpq_ctrl.sv =====
// Sequencer for the route request packet queue: orders the walk passes and the emit phase.
// Depends on rrpq_pkg.
module rrpq_ctrl
    import rrpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_opcode,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PURGE  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_OLD    = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.accept = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_opcode;
                    if (i_opcode inside {OP_ENQ, OP_DEQ, OP_DROP, OP_SIZE}) begin
                        n_state = S_PURGE;
                    end else if (i_opcode inside {OP_TICK, OP_FIND}) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_PURGE: begin
                o_cmd.walk = 1'b1;
                o_cmd.mode = M_PURGE;
                if (i_stat.walk_done) begin
                    n_state = (r_op == OP_SIZE) ? S_EMIT : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                case (r_op)
                    OP_TICK: o_cmd.mode = M_TICK;
                    OP_ENQ:  o_cmd.mode = M_DUP;
                    OP_DEQ:  o_cmd.mode = M_DEQ;
                    OP_DROP: o_cmd.mode = M_DEST;
                    default: o_cmd.mode = M_FIND;
                endcase
                if (i_stat.walk_done) begin
                    n_state = (r_op == OP_ENQ && !i_stat.hit) ? S_OLD : S_EMIT;
                end
            end
            S_OLD: begin
                o_cmd.walk = 1'b1;
                o_cmd.mode = M_OLD;
                if (i_stat.walk_done) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TICK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

// ===== sv/rrpq_datapath.sv =====
// Entry store, compaction walker and drop buffer for the route request packet queue.
// Depends on rrpq_pkg.
module rrpq_datapath
    import rrpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_packet_id,
    input  logic [15:0] i_dest_addr,
    input  logic [4:0]  i_max_length,
    input  logic [15:0] i_lifetime,
    output logic [1:0]  o_kind,
    output logic [31:0] o_out_packet_id,
    output logic [15:0] o_out_dest_addr,
    output logic        o_success,
    output logic [4:0]  o_occupancy,
    output logic        o_last
);

    logic [31:0]      q_id   [QUEUE_DEPTH];
    logic [15:0]      q_dest [QUEUE_DEPTH];
    logic [AGE_W-1:0] q_age  [QUEUE_DEPTH];

    logic [31:0] b_id   [QUEUE_DEPTH];
    logic [15:0] b_dest [QUEUE_DEPTH];
    logic [1:0]  b_kind [QUEUE_DEPTH];

    logic [CW-1:0] r_count, r_rd, r_wr, r_nd, r_ed;
    logic [2:0]    r_op;
    logic [31:0]   r_id, r_rid;
    logic [15:0]   r_dest, r_rdest;
    logic          r_found, r_hit;

    logic [31:0]      e_id;
    logic [15:0]      e_dest;
    logic [AGE_W-1:0] e_age, e_age_next;
    logic             in_range, remove, push;
    logic [1:0]       push_kind;
    logic [CW-1:0]    lim, live;
    logic             have_drop, succ;

    assign in_range   = (r_rd < r_count);
    assign e_id       = q_id[r_rd[IW-1:0]];
    assign e_dest     = q_dest[r_rd[IW-1:0]];
    assign e_age      = q_age[r_rd[IW-1:0]];
    assign e_age_next = (i_cmd.mode == M_TICK && e_age != {AGE_W{1'b1}}) ?
                        e_age + AGE_W'(1) : e_age;
    assign live       = r_count - (r_rd - r_wr);

    always_comb begin
        if (i_max_length == 5'd0) begin
            lim = CW'(1);
        end else if (32'(i_max_length) > QUEUE_DEPTH) begin
            lim = CW'(QUEUE_DEPTH);
        end else begin
            lim = CW'(i_max_length);
        end
    end

    always_comb begin
        remove    = 1'b0;
        push      = 1'b0;
        push_kind = K_EXP;
        case (i_cmd.mode)
            M_PURGE: begin
                remove = (e_age > {1'b0, i_lifetime});
                push   = remove;
            end
            M_DEST: begin
                remove    = (e_dest == r_dest);
                push      = remove;
                push_kind = K_DST;
            end
            M_OLD: begin
                remove    = (live >= lim);
                push      = remove;
                push_kind = K_OLD;
            end
            M_DEQ: begin
                remove = !r_found && (e_dest == r_dest);
            end
            default: begin
                remove = 1'b0;
            end
        endcase
    end

    assign o_stat.walk_done = i_cmd.walk && !in_range;
    assign o_stat.hit       = r_hit;
    assign have_drop        = (r_ed < r_nd);
    assign o_stat.emit_end  = i_cmd.emit && !have_drop;

    always_comb begin
        case (r_op)
            OP_ENQ:  succ = !r_hit;
            OP_DEQ:  succ = r_found;
            OP_FIND: succ = r_hit;
            default: succ = 1'b0;
        endcase
    end

    assign o_kind          = have_drop ? b_kind[r_ed[IW-1:0]] : K_DONE;
    assign o_out_packet_id = have_drop ? b_id[r_ed[IW-1:0]]   : r_rid;
    assign o_out_dest_addr = have_drop ? b_dest[r_ed[IW-1:0]] : r_rdest;
    assign o_success       = have_drop ? 1'b0 : succ;
    assign o_last          = !have_drop;
    assign o_occupancy     = OCC_W'(r_count);

    // entry and drop buffer storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk && in_range) begin
            if (push) begin
                b_id[r_nd[IW-1:0]]   <= e_id;
                b_dest[r_nd[IW-1:0]] <= e_dest;
                b_kind[r_nd[IW-1:0]] <= push_kind;
            end
            if (!remove) begin
                q_id[r_wr[IW-1:0]]   <= e_id;
                q_dest[r_wr[IW-1:0]] <= e_dest;
                q_age[r_wr[IW-1:0]]  <= e_age_next;
            end
        end
        if (i_cmd.append && r_count < CW'(QUEUE_DEPTH)) begin
            q_id[r_count[IW-1:0]]   <= r_id;
            q_dest[r_count[IW-1:0]] <= r_dest;
            q_age[r_count[IW-1:0]]  <= '0;
        end
        if (i_cmd.accept) begin
            r_id   <= i_packet_id;
            r_dest <= i_dest_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_nd    <= '0;
            r_ed    <= '0;
            r_op    <= OP_TICK;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
            r_rid   <= '0;
            r_rdest <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_op    <= i_opcode;
                r_rd    <= '0;
                r_wr    <= '0;
                r_nd    <= '0;
                r_ed    <= '0;
                r_found <= 1'b0;
                r_hit   <= 1'b0;
                r_rid   <= '0;
                r_rdest <= '0;
            end
            if (i_cmd.walk) begin
                if (in_range) begin
                    r_rd <= r_rd + CW'(1);
                    if (!remove) begin
                        r_wr <= r_wr + CW'(1);
                    end
                    if (push) begin
                        r_nd <= r_nd + CW'(1);
                    end
                    if (i_cmd.mode == M_DEQ && remove) begin
                        r_found <= 1'b1;
                        r_rid   <= e_id;
                        r_rdest <= e_dest;
                    end
                    if (i_cmd.mode == M_DUP && e_id == r_id && e_dest == r_dest) begin
                        r_hit <= 1'b1;
                    end
                    if (i_cmd.mode == M_FIND && e_dest == r_dest) begin
                        r_hit <= 1'b1;
                    end
                end else begin
                    r_count <= r_wr;
                    r_rd    <= '0;
                    r_wr    <= '0;
                end
            end
            if (i_cmd.append && r_count < CW'(QUEUE_DEPTH)) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit && have_drop) begin
                r_ed <= r_ed + CW'(1);
            end
        end
    end

endmodule

// ===== bench/rrpq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the route request packet queue: tracks accepted commands and register
// writes, predicts the result words in order and compares them. Depends on rrpq_pkg.
module rrpq_checker
    import rrpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_packet_id,
    input  logic [15:0] i_dest_addr,
    input  logic        o_strobe,
    input  logic [1:0]  o_kind,
    input  logic [31:0] o_out_packet_id,
    input  logic [15:0] o_out_dest_addr,
    input  logic        o_success,
    input  logic [4:0]  o_occupancy,
    input  logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pkt;
        logic [15:0] dst;
        logic        ok;
        logic [4:0]  occ;
        logic        last;
    } t_word;

    logic [31:0]     q_ids  [QUEUE_DEPTH];
    logic [15:0]     q_dsts [QUEUE_DEPTH];
    logic [AGE_W-1:0] q_ages [QUEUE_DEPTH];
    int              q_count;
    logic [4:0]      max_len;
    logic [15:0]     life;
    t_word           expected_words[$];
    t_word           op_words[$];
    int              fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    function automatic void remove_entry(int k);
        for (int i = k; i + 1 < q_count; i++) begin
            q_ids[i]  = q_ids[i+1];
            q_dsts[i] = q_dsts[i+1];
            q_ages[i] = q_ages[i+1];
        end
        if (q_count > 0) q_count--;
    endfunction

    function automatic void push_word(logic [1:0] k, logic [31:0] p, logic [15:0] d, logic s);
        t_word w;
        w = '{kind: k, pkt: p, dst: d, ok: s, occ: 5'd0, last: 1'b0};
        op_words.insert(op_words.size(), w);
    endfunction

    function automatic void sweep_queue(bit by_dest, logic [15:0] d);
        int  i;
        bit  hit;
        i = 0;
        while (i < q_count) begin
            hit = by_dest ? (q_dsts[i] == d) : (q_ages[i] > {1'b0, life});
            if (hit) begin
                push_word(by_dest ? K_DST : K_EXP, q_ids[i], q_dsts[i], 1'b0);
                remove_entry(i);
            end else begin
                i++;
            end
        end
    endfunction

    function automatic void predict_queue_op(logic [2:0] op, logic [31:0] id, logic [15:0] d);
        int          lim;
        logic        ok;
        logic [31:0] rid;
        logic [15:0] rdst;
        bit          dup;
        ok = 0; rid = 0; rdst = 0; dup = 0;
        lim = (max_len == 0) ? 1 : (max_len > QUEUE_DEPTH ? QUEUE_DEPTH : max_len);
        op_words.delete();
        if (op == OP_ENQ || op == OP_DEQ || op == OP_DROP || op == OP_SIZE)
            sweep_queue(1'b0, 16'd0);
        case (op)
            OP_TICK: begin
                for (int i = 0; i < q_count; i++)
                    if (q_ages[i] != '1) q_ages[i]++;
            end
            OP_ENQ: begin
                for (int i = 0; i < q_count; i++)
                    if (q_ids[i] == id && q_dsts[i] == d) dup = 1;
                if (!dup) begin
                    while (q_count >= lim && q_count > 0) begin
                        push_word(K_OLD, q_ids[0], q_dsts[0], 1'b0);
                        remove_entry(0);
                    end
                    if (q_count < QUEUE_DEPTH) begin
                        q_ids[q_count]  = id;
                        q_dsts[q_count] = d;
                        q_ages[q_count] = '0;
                        q_count++;
                    end
                    ok = 1;
                end
            end
            OP_DEQ: begin
                for (int i = 0; i < q_count; i++) begin
                    if (q_dsts[i] == d) begin
                        rid = q_ids[i]; rdst = q_dsts[i]; ok = 1;
                        remove_entry(i);
                        break;
                    end
                end
            end
            OP_DROP: sweep_queue(1'b1, d);
            OP_FIND: begin
                for (int i = 0; i < q_count; i++)
                    if (q_dsts[i] == d) ok = 1;
            end
            default: ;
        endcase
        push_word(K_DONE, rid, rdst, ok);
        op_words[op_words.size()-1].last = 1'b1;
        foreach (op_words[k]) begin
            op_words[k].occ = q_count[4:0];
            expected_words.insert(expected_words.size(), op_words[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_word got, exp_w;
        if (!i_rst_n) begin
            q_count = 0;
            max_len = 5'd16;
            life    = 16'd30;
            fails   = 0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == CFG_LIFETIME) life = pwdata[15:0];
                else max_len = pwdata[4:0];
            end
            if (start && !busy) predict_queue_op(i_opcode, i_packet_id, i_dest_addr);
            if (o_strobe) begin
                got = '{kind: o_kind, pkt: o_out_packet_id, dst: o_out_dest_addr,
                        ok: o_success, occ: o_occupancy, last: o_last};
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected word: %p", got);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        fails++;
                        if (fails <= 10) $display("word mismatch: expected %p got %p", exp_w, got);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the route request packet queue: register phases, directed
// and random commands. Depends on rrpq_pkg, route_request_packet_queue_top, rrpq_checker.
module tb_top;
    import rrpq_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_opcode = 0;
    logic [31:0] i_packet_id = 0;
    logic [15:0] i_dest_addr = 0;
    logic        o_strobe, o_success, o_last;
    logic [1:0]  o_kind;
    logic [31:0] o_out_packet_id;
    logic [15:0] o_out_dest_addr;
    logic [4:0]  o_occupancy;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    logic [15:0] dest_pool[4];
    logic [31:0] id_pool[4];

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    route_request_packet_queue_top dut (.*);
    rrpq_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain_queue();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return;
        repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge i_clk);
    endtask

    task automatic send_op(logic [2:0] op, logic [31:0] id, logic [15:0] d);
        start <= 1; i_opcode <= op; i_packet_id <= id; i_dest_addr <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_random_op(bit noisy);
        logic [2:0] op;
        int         r;
        r = $urandom_range(0, 99);
        if (noisy && r < 8) op = ($urandom_range(0, 1) != 0) ? OP_RSVD_B : OP_RSVD_A;
        else if (r < 25) op = OP_TICK;
        else if (r < 55) op = OP_ENQ;
        else if (r < 70) op = OP_DEQ;
        else if (r < 80) op = OP_DROP;
        else if (r < 90) op = OP_FIND;
        else op = OP_SIZE;
        send_op(op, noisy ? $urandom : id_pool[$urandom_range(0, 3)],
                noisy ? 16'($urandom) : dest_pool[$urandom_range(0, 3)]);
        idle_gap();
    endtask

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_op(OP_SIZE, 0, 0);
        send_op(OP_DEQ, 0, 16'h1234);
        send_op(OP_RSVD_A, '1, '1);
        send_op(OP_RSVD_B, 0, 0);
        for (int i = 0; i < 17; i++) send_op(OP_ENQ, 32'hFFFF_FFF0 + i, 16'hFFFF - i[15:0]);
        send_op(OP_ENQ, 32'hFFFF_FFF5, 16'hFFFA);
        send_op(OP_FIND, 0, 16'hFFFF);
        send_op(OP_FIND, 0, 16'h0000);
        send_op(OP_DEQ, 0, 16'hFFFA);
        send_op(OP_DROP, 0, 16'hFFFB);
        drain_queue();

        write_reg(3'd4, 32'd0);
        for (int i = 0; i < 3; i++) send_op(OP_TICK, 0, 0);
        send_op(OP_SIZE, 0, 0);
        send_op(OP_ENQ, 32'h0, 16'h0);
        send_op(OP_TICK, 0, 0);
        send_op(OP_DROP, 0, 16'h0);
        drain_queue();
        write_reg(3'd0, 32'd1);
        write_reg(3'd4, 32'hFFFF);
        drain_queue();

        for (int ph = 0; ph < 6; ph++) begin
            for (int j = 0; j < 4; j++) begin
                dest_pool[j] = 16'($urandom);
                id_pool[j]   = $urandom;
            end
            case (ph)
                0: begin write_reg(3'd0, 32'd16); write_reg(3'd4, 32'd30); end
                1: begin write_reg(3'd0, 32'd0);  write_reg(3'd4, 32'd5); end
                2: begin write_reg(3'd0, 32'd31); write_reg(3'd4, 32'd2); end
                3: begin write_reg(3'd0, 32'd4);  write_reg(3'd4, 32'd0); end
                4: begin write_reg(3'd0, 32'd12); write_reg(3'd4, 32'hFFFF); end
                default: begin write_reg(3'd0, $urandom_range(1, 16));
                               write_reg(3'd4, $urandom_range(0, 40)); end
            endcase
            for (int n = 0; n < 60; n++) begin
                send_random_op($urandom_range(0, 9) == 0);
                if (n == 30) while (pending != 0) @(posedge i_clk);
            end
            drain_queue();
        end

        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

// ===== route_request_packet_queue_top.f =====
sv/rrpq_pkg.sv
sv/rrpq_ctrl.sv
sv/rrpq_datapath.sv
sv/route_request_packet_queue_top.sv
bench/rrpq_checker.sv
bench/tb_top.sv
